>>> hw/rtl/utf8d_pkg.sv
// Shared types, status codes and lead byte constants for the extended UTF-8 decoder.
package utf8d_pkg;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_LEAD = 2'd1;
    localparam logic [1:0] ST_NO_CONT  = 2'd2;
    localparam logic [1:0] ST_OPEN_END = 2'd3;

    localparam logic [7:0] CONT_MASK  = 8'hc0;
    localparam logic [7:0] CONT_MARK  = 8'h80;
    localparam logic [7:0] CONT_BITS  = 8'h3f;
    localparam logic [7:0] ASCII_BITS = 8'h7f;
    localparam logic [7:0] LEAD2_BITS = 8'h1f;
    localparam logic [7:0] LEAD3_BITS = 8'h0f;
    localparam logic [7:0] LEAD4_BITS = 8'h07;
    localparam logic [7:0] LEAD5_BITS = 8'h03;

    localparam int unsigned REM_W = 3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_end;
    } in_item_t;

    typedef struct packed {
        logic [31:0] code_point;
        logic [1:0]  status;
    } out_item_t;

    typedef struct packed {
        logic [31:0]      partial_value;
        logic [REM_W-1:0] bytes_remaining;
        logic             halted;
    } dec_state_t;

    typedef struct packed {
        dec_state_t state;
        logic       emit;
        out_item_t  res;
    } step_t;

endpackage

>>> hw/rtl/utf8d_step.sv
// Decode step: next state and optional result for one request.
module utf8d_step
    import utf8d_pkg::*;
(
    input  dec_state_t cur,
    input  in_item_t   item,
    output step_t      step
);

    logic [7:0]  b;
    logic [31:0] shifted;

    assign b       = item.data_byte;
    assign shifted = {cur.partial_value[25:0], b[5:0]};

    always_comb
    begin
        step                     = '0;
        step.state               = cur;
        step.res.status          = ST_OK;
        step.res.code_point      = '0;
        if (item.stream_end)
        begin
            step.state = '0;
            if ((cur.bytes_remaining != '0) && !cur.halted)
            begin
                step.emit       = 1'b1;
                step.res.status = ST_OPEN_END;
            end
        end
        else if (cur.halted)
        begin
            step.state = cur;
        end
        else if (cur.bytes_remaining != '0)
        begin
            if ((b & CONT_MASK) != CONT_MARK)
            begin
                step.state        = '0;
                step.state.halted = 1'b1;
                step.emit         = 1'b1;
                step.res.status   = ST_NO_CONT;
            end
            else if (cur.bytes_remaining == REM_W'(1))
            begin
                step.state.partial_value   = '0;
                step.state.bytes_remaining = '0;
                step.emit                  = 1'b1;
                step.res.code_point        = shifted;
            end
            else
            begin
                step.state.partial_value   = shifted;
                step.state.bytes_remaining = cur.bytes_remaining - REM_W'(1);
            end
        end
        else
        begin
            casez (b)
                8'b0???????:
                begin
                    step.emit           = 1'b1;
                    step.res.code_point = {24'd0, b & ASCII_BITS};
                end
                8'b10??????:
                begin
                    step.state.halted = 1'b1;
                    step.emit         = 1'b1;
                    step.res.status   = ST_BAD_LEAD;
                end
                8'b110?????:
                begin
                    step.state.partial_value   = {24'd0, b & LEAD2_BITS};
                    step.state.bytes_remaining = REM_W'(1);
                end
                8'b1110????:
                begin
                    step.state.partial_value   = {24'd0, b & LEAD3_BITS};
                    step.state.bytes_remaining = REM_W'(2);
                end
                8'b11110???:
                begin
                    step.state.partial_value   = {24'd0, b & LEAD4_BITS};
                    step.state.bytes_remaining = REM_W'(3);
                end
                8'b111110??:
                begin
                    step.state.partial_value   = {24'd0, b & LEAD5_BITS};
                    step.state.bytes_remaining = REM_W'(4);
                end
                default:
                begin
                    step.state.partial_value   = {24'd0, b & LEAD5_BITS};
                    step.state.bytes_remaining = REM_W'(5);
                end
            endcase
        end
    end

endmodule

>>> hw/rtl/utf8d_out_stage.sv
// Result register with valid/stall handshake toward the consumer.
module utf8d_out_stage
    import utf8d_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  out_item_t load_item,
    output logic      free,
    output logic      dst_valid,
    input  logic      dst_stall,
    output out_item_t dst_data
);

    logic      valid_reg;
    logic      valid_next;
    out_item_t data_reg;

    assign free       = !valid_reg || !dst_stall;
    assign valid_next = load || (valid_reg && dst_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_item;
        end
    end

    assign dst_valid = valid_reg;
    assign dst_data  = data_reg;

endmodule

>>> hw/rtl/utf8_extended_decoder.sv
// Top level of the extended UTF-8 (32-bit) stream decoder.
//
//   channel | direction | payload     | handshake
//   src     | in        | in_item_t   | src_valid / src_stall
//   dst     | out       | out_item_t  | dst_valid / dst_stall
//
// One request per cycle is taken while src_stall is low; each passes the input register, then the
// decode step, and its result (if any) lands in the result register.
// The result register drives dst_valid, and a stalled result register holds back a new result.
// Reset clears the decode state, the halt flag and both valid bits.
// A stalled result holds; the input register drains when the step gives no
// result or the result register is free, else src_stall rises.
module utf8_extended_decoder
    import utf8d_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      src_valid,
    output logic      src_stall,
    input  in_item_t  src_data,
    output logic      dst_valid,
    input  logic      dst_stall,
    output out_item_t dst_data
);

    logic       in_valid_reg;
    logic       in_valid_next;
    in_item_t   in_item_reg;
    dec_state_t state_reg;
    step_t      step;
    logic       out_free;
    logic       advance;
    logic       take;

    utf8d_step u_step (
        .cur  (state_reg),
        .item (in_item_reg),
        .step (step)
    );

    assign advance       = in_valid_reg && (out_free || !step.emit);
    assign src_stall     = in_valid_reg && !advance;
    assign take          = src_valid && !src_stall;
    assign in_valid_next = take || (in_valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            state_reg    <= '0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (advance)
            begin
                state_reg <= step.state;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_item_reg <= src_data;
        end
    end

    utf8d_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && step.emit),
        .load_item (step.res),
        .free      (out_free),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_data  (dst_data)
    );

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && (dst_data.status != ST_OK) |-> dst_data.code_point == '0)
        else $error("error result carries nonzero code point");

    a_halt_after_err: assert property (@(posedge clk) disable iff (!rst_n)
        advance && step.emit &&
        (step.res.status == ST_BAD_LEAD || step.res.status == ST_NO_CONT)
        |=> state_reg.halted)
        else $error("byte error did not halt decoder");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_item_reg.stream_end
        |=> state_reg.bytes_remaining == '0 && !state_reg.halted)
        else $error("end request did not clear state");

    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.bytes_remaining <= REM_W'(5))
        else $error("continuation count out of range");

endmodule

>>> dv/tb_utf8_extended_decoder.sv
// Self-checking testbench for the extended UTF-8 stream decoder.
`timescale 1ns / 100ps

module tb_utf8_extended_decoder;
    import utf8d_pkg::*;

    localparam int unsigned N_BYTES        = 1450;
    localparam int unsigned HOLD_A         = 300;
    localparam int unsigned HOLD_B         = 1000;
    localparam int unsigned LONG_HOLD      = 150;
    localparam int unsigned DRAIN_AT       = 800;
    localparam int unsigned WATCHDOG_LIMIT = 3000;
    localparam int unsigned MAX_REPORTS    = 10;

    typedef struct {
        in_item_t item;
        bit       wait_drain;
    } pending_t;

    logic      clk;
    logic      rst_n;
    logic      src_valid = 1'b0;
    logic      src_stall;
    in_item_t  src_data  = '0;
    logic      dst_valid;
    logic      dst_stall = 1'b0;
    out_item_t dst_data;

    pending_t    pending_bytes[$];
    out_item_t   expected_points[$];

    logic [31:0] acc_value   = '0;
    logic [2:0]  cont_left   = '0;
    logic        dec_halted  = 1'b0;

    bit          src_fire    = 1'b0;
    int unsigned taken_count = 0;
    int unsigned idle_cycles = 0;
    int unsigned mismatches  = 0;

    int unsigned gap_left    = 0;
    int unsigned tx_burst    = 0;
    int unsigned rx_hold     = 0;
    int unsigned rx_wait     = 0;
    int unsigned rx_burst    = 0;
    bit [1:0]    holds_done  = '0;

    utf8_extended_decoder i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_data  (src_data),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_data  (dst_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 92)
            return $urandom_range(4, 8);
        else
            return $urandom_range(10, 40);
    endfunction

    function automatic logic [7:0] lead_byte(input int unsigned n);
        logic [7:0] b;
        b = 8'($urandom);
        case (n)
            0:       b = {1'b0, b[6:0]};
            1:       b = {3'b110, b[4:0]};
            2:       b = {4'b1110, b[3:0]};
            3:       b = {5'b11110, b[2:0]};
            4:       b = {6'b111110, b[1:0]};
            default: b = {6'b111111, b[1:0]};
        endcase
        return b;
    endfunction

    function automatic logic [7:0] cont_byte();
        logic [7:0] b;
        b = 8'($urandom);
        return {2'b10, b[5:0]};
    endfunction

    task automatic add_byte(input logic [7:0] b);
        pending_t p;
        p.item.data_byte  = b;
        p.item.stream_end = 1'b0;
        p.wait_drain      = 1'b0;
        pending_bytes.push_back(p);
    endtask

    task automatic add_end(input logic [7:0] b);
        pending_t p;
        p.item.data_byte  = b;
        p.item.stream_end = 1'b1;
        p.wait_drain      = 1'b0;
        pending_bytes.push_back(p);
    endtask

    task automatic push_result(input logic [31:0] value, input logic [1:0] status);
        out_item_t r;
        r.code_point = value;
        r.status     = status;
        expected_points.push_back(r);
    endtask

    task automatic decode_byte(input in_item_t it);
        logic [7:0] b;
        logic       open_seq;
        b = it.data_byte;
        if (it.stream_end)
        begin
            open_seq   = (cont_left != 0) && !dec_halted;
            acc_value  = '0;
            cont_left  = '0;
            dec_halted = 1'b0;
            if (open_seq)
                push_result('0, ST_OPEN_END);
        end
        else if (dec_halted)
        begin
        end
        else if (cont_left != 0)
        begin
            if ((b & CONT_MASK) != CONT_MARK)
            begin
                acc_value  = '0;
                cont_left  = '0;
                dec_halted = 1'b1;
                push_result('0, ST_NO_CONT);
            end
            else
            begin
                acc_value = {acc_value[25:0], b[5:0]};
                cont_left = cont_left - 3'd1;
                if (cont_left == 0)
                begin
                    push_result(acc_value, ST_OK);
                    acc_value = '0;
                end
            end
        end
        else
        begin
            casez (b)
                8'b0???????:
                    push_result({24'd0, b & ASCII_BITS}, ST_OK);
                8'b10??????:
                begin
                    dec_halted = 1'b1;
                    push_result('0, ST_BAD_LEAD);
                end
                8'b110?????:
                begin
                    acc_value = {24'd0, b & LEAD2_BITS};
                    cont_left = 3'd1;
                end
                8'b1110????:
                begin
                    acc_value = {24'd0, b & LEAD3_BITS};
                    cont_left = 3'd2;
                end
                8'b11110???:
                begin
                    acc_value = {24'd0, b & LEAD4_BITS};
                    cont_left = 3'd3;
                end
                8'b111110??:
                begin
                    acc_value = {24'd0, b & LEAD5_BITS};
                    cont_left = 3'd4;
                end
                default:
                begin
                    acc_value = {24'd0, b & LEAD5_BITS};
                    cont_left = 3'd5;
                end
            endcase
        end
    endtask

    initial
    begin
        int unsigned r;
        int unsigned n;
        int unsigned k;
        logic [7:0]  b;

        add_byte(8'h00);
        add_byte(8'h7f);
        add_byte(8'hc0); add_byte(8'h80);
        add_byte(8'hdf); add_byte(8'hbf);
        add_byte(8'hff); repeat (5) add_byte(8'hbf);
        add_byte(8'hfc); repeat (5) add_byte(8'h80);
        add_byte(8'h80); add_byte(8'h41); add_end(8'h00);
        add_byte(8'hbf); add_end(8'hff);
        add_byte(8'he0); add_byte(8'hc0); add_byte(8'h41); add_end(8'h00);
        add_byte(8'hf8); add_byte(8'h80); add_end(8'h00);
        add_end(8'h5a);

        while (pending_bytes.size() < N_BYTES)
        begin
            if (pending_bytes.size() >= DRAIN_AT && pending_bytes.size() < DRAIN_AT + 8)
                add_byte(8'h41);
            r = $urandom_range(0, 99);
            if (r < 70)
            begin
                n = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 5);
                add_byte(lead_byte(n));
                repeat (n) add_byte(cont_byte());
            end
            else if (r < 78)
                add_end(8'($urandom));
            else if (r < 84)
            begin
                n = $urandom_range(1, 5);
                k = $urandom_range(0, n - 1);
                add_byte(lead_byte(n));
                repeat (k) add_byte(cont_byte());
                add_end(8'($urandom));
            end
            else if (r < 90)
            begin
                n = $urandom_range(1, 5);
                k = $urandom_range(0, n - 1);
                add_byte(lead_byte(n));
                repeat (k) add_byte(cont_byte());
                b = 8'($urandom);
                while ((b & CONT_MASK) == CONT_MARK)
                    b = 8'($urandom);
                add_byte(b);
                repeat ($urandom_range(0, 3)) add_byte(8'($urandom));
                add_end(8'($urandom));
            end
            else if (r < 95)
            begin
                add_byte(cont_byte());
                repeat ($urandom_range(0, 3)) add_byte(8'($urandom));
                add_end(8'($urandom));
            end
            else
                add_byte(8'($urandom));
        end
        pending_bytes[29].wait_drain       = 1'b1;
        pending_bytes[DRAIN_AT].wait_drain = 1'b1;

        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_bytes.size() != 0 || src_valid)
            @(negedge clk);
        while (expected_points.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);

        if (mismatches == 0 && expected_points.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    always @(negedge clk)
    begin
        int unsigned r;
        if (!rst_n)
        begin
        end
        else if (src_valid && !src_fire)
        begin
        end
        else if (gap_left > 0)
        begin
            gap_left  = gap_left - 1;
            src_valid <= 1'b0;
        end
        else if (pending_bytes.size() == 0)
            src_valid <= 1'b0;
        else if (pending_bytes[0].wait_drain && expected_points.size() != 0)
            src_valid <= 1'b0;
        else
        begin
            src_data  <= pending_bytes[0].item;
            src_valid <= 1'b1;
            void'(pending_bytes.pop_front());
            if (tx_burst > 0)
            begin
                tx_burst = tx_burst - 1;
                gap_left = 0;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 3)
                    tx_burst = $urandom_range(20, 60);
                gap_left = (r < 55) ? 0 : idle_len();
            end
            if ((taken_count + 8 >= HOLD_A && taken_count < HOLD_A + 8) ||
                (taken_count + 8 >= HOLD_B && taken_count < HOLD_B + 8))
                gap_left = 0;
        end
    end

    always @(negedge clk)
    begin
        logic        stall_next;
        int unsigned r;
        stall_next = 1'b0;
        if (rx_hold > 0)
        begin
            rx_hold    = rx_hold - 1;
            stall_next = 1'b1;
        end
        else if (taken_count >= HOLD_A && !holds_done[0])
        begin
            holds_done[0] = 1'b1;
            rx_hold       = LONG_HOLD - 1;
            stall_next    = 1'b1;
        end
        else if (taken_count >= HOLD_B && !holds_done[1])
        begin
            holds_done[1] = 1'b1;
            rx_hold       = LONG_HOLD - 1;
            stall_next    = 1'b1;
        end
        else if (rx_wait > 0)
        begin
            rx_wait    = rx_wait - 1;
            stall_next = 1'b1;
        end
        else if (rx_burst > 0)
            rx_burst = rx_burst - 1;
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 3)
                rx_burst = $urandom_range(20, 60);
            else if (r >= 50)
            begin
                rx_wait    = idle_len() - 1;
                stall_next = 1'b1;
            end
        end
        dst_stall <= stall_next;
    end

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n)
        begin
            src_fire <= src_valid && !src_stall;
            if (dst_valid && !dst_stall)
            begin
                if (expected_points.size() == 0)
                begin
                    if (mismatches < MAX_REPORTS)
                        $display("[%0t] unexpected result: code_point=%h status=%0d",
                                 $realtime, dst_data.code_point, dst_data.status);
                    mismatches = mismatches + 1;
                end
                else
                begin
                    want = expected_points.pop_front();
                    if (want.code_point !== dst_data.code_point ||
                        want.status !== dst_data.status)
                    begin
                        if (mismatches < MAX_REPORTS)
                            $display("[%0t] expected code_point=%h status=%0d, got %h %0d",
                                     $realtime, want.code_point, want.status,
                                     dst_data.code_point, dst_data.status);
                        mismatches = mismatches + 1;
                    end
                end
            end
            if (src_valid && !src_stall)
            begin
                decode_byte(src_data);
                taken_count <= taken_count + 1;
            end
            if ((src_valid && !src_stall) || (dst_valid && !dst_stall))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

endmodule
